[rtl/core/tlma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tlma_pkg;

   // Field and datapath widths
   localparam int TIME_W   = 32;
   localparam int MODE_W   = 3;
   localparam int PCT_W    = 7;
   localparam int TENS_W   = 8;
   localparam int CHAN_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int DIVR_W   = 12;   // divisor / remainder width, covers 2550 ms
   localparam int SCALE_W  = 15;   // level * percent, at most 255 * 127
   localparam int RECIP_W  = 13;
   localparam int SCALED_W = SCALE_W + RECIP_W;
   localparam int RECIP_SHIFT = 19;
   localparam int FLASH_W  = 7;    // position inside one 100 ms flash window

   // floor(x / 100) == (x * 5243) >> 19 for every x below 2^15
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   // Timing constants in milliseconds
   localparam logic [TIME_W-1:0]  FRAME_MS    = 32'd20;
   localparam logic [TIME_W-1:0]  IDENTIFY_MS = 32'd5000;
   localparam logic [FLASH_W-1:0] FLASH_MS    = 7'd100;

   // Opcodes
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_SET_MODE = 1'b1;

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_PROGRAM      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PREVIEW      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STANDBY      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AMBER        = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WHITE_BREATH = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PAIRING      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_IDENTIFY     = 3'd6;
   localparam logic [MODE_W-1:0] MODE_INVALID      = 3'd7;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_BRIGHT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STBY_BRIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BREATH_TENS  = 2'd2;

   // Register reset values
   localparam logic [PCT_W-1:0]  MAIN_BRIGHT_RST = 7'd80;
   localparam logic [PCT_W-1:0]  STBY_BRIGHT_RST = 7'd20;
   localparam logic [TENS_W-1:0] BREATH_TENS_RST = 8'd40;

   typedef struct packed {
      logic              opcode;
      logic [MODE_W-1:0] new_mode;
   } req_data_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [MODE_W-1:0] shown_mode;
   } rsp_data_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SELECT,
      ST_MOD_RUN,
      ST_IDX_RUN,
      ST_LOOKUP,
      ST_SCALE_A,
      ST_SCALE_B,
      ST_FORM
   } state_type;

   // Divider operand selection
   typedef enum logic {
      DIV_MOD,     // elapsed mod period
      DIV_IDX      // remainder * entries / period
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        frame_start;
      logic        div_start;
      div_sel_type div_sel;
      logic        load_bright;
      logic        emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic              frame_due;
      logic [MODE_W-1:0] mode;
      logic              div_done;
      logic              out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/tlma_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module tlma_div
   import tlma_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TIME_W-1:0] dividend,
   input  wire logic [DIVR_W-1:0] divisor,
   output logic                   done,
   output logic [TIME_W-1:0]      quotient,
   output logic [DIVR_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(TIME_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TIME_W-1:0]   quot_ff, quot_in;
   logic [DIVR_W-1:0]   rem_ff, rem_in;
   logic [DIVR_W-1:0]   divisor_ff, divisor_in;
   logic [DIVR_W:0]     trial;
   logic                fits;

   // Trial subtract of the shifted partial remainder
   assign trial = {rem_ff, quot_ff[TIME_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(TIME_W - 1);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[TIME_W-2:0], fits};
         rem_in  = fits ? DIVR_W'(trial - {1'b0, divisor_ff}) : trial[DIVR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/core/tlma_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlma_dp
   import tlma_pkg::*;
#(
   parameter int BREATH_TABLE_ENTRIES = 256
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   input  wire req_data_type          req_data,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_data_type               rsp_data
);

   localparam int N       = BREATH_TABLE_ENTRIES;
   localparam int IDX_W   = $clog2(N);
   localparam int N_W     = $clog2(N + 1);
   localparam int PROD_W  = DIVR_W + N_W;
   localparam logic [N_W-1:0]   N_VAL  = N_W'(N);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(N - 1);

   // Raised-cosine table, worked out at elaboration
   logic [CHAN_W-1:0] breath_rom [N];

   for (genvar gi = 0; gi < N; gi++) begin : g_rom
      localparam longint unsigned P = longint'(gi) * longint'(N - gi);
      localparam longint unsigned D = 64'd5 * longint'(N) * longint'(N) - 64'd4 * P;
      localparam longint unsigned V = (64'd65280 * P * P) / (D * D);
      assign breath_rom[gi] = (V > 64'd255) ? 8'd255 : 8'(V);
   end

   // Configuration registers
   logic [PCT_W-1:0]  main_bright_ff, main_bright_in;
   logic [PCT_W-1:0]  stby_bright_ff, stby_bright_in;
   logic [TENS_W-1:0] breath_tens_ff, breath_tens_in;

   always_comb begin
      main_bright_in = main_bright_ff;
      stby_bright_in = stby_bright_ff;
      breath_tens_in = breath_tens_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAIN_BRIGHT: main_bright_in = csr_wdata[PCT_W-1:0];
            CSR_STBY_BRIGHT: stby_bright_in = csr_wdata[PCT_W-1:0];
            CSR_BREATH_TENS: breath_tens_in = csr_wdata[TENS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_bright_ff <= MAIN_BRIGHT_RST;
         stby_bright_ff <= STBY_BRIGHT_RST;
         breath_tens_ff <= BREATH_TENS_RST;
      end else begin
         main_bright_ff <= main_bright_in;
         stby_bright_ff <= stby_bright_in;
         breath_tens_ff <= breath_tens_in;
      end
   end

   // Time and mode state
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]  last_frame_ff, last_frame_in;
   logic [TIME_W-1:0]  id_start_ff, id_start_in;
   logic [MODE_W-1:0]  active_mode_ff, active_mode_in;
   logic [MODE_W-1:0]  saved_mode_ff, saved_mode_in;
   logic [FLASH_W-1:0] flash_cnt_ff, flash_cnt_in;
   logic               flash_odd_ff, flash_odd_in;
   logic               id_expired;

   assign id_expired = ((elapsed_ff - id_start_ff) >= IDENTIFY_MS);

   always_comb begin
      elapsed_in     = elapsed_ff;
      last_frame_in  = last_frame_ff;
      id_start_in    = id_start_ff;
      active_mode_in = active_mode_ff;
      saved_mode_in  = saved_mode_ff;
      flash_cnt_in   = flash_cnt_ff;
      flash_odd_in   = flash_odd_ff;
      if (cmd.accept) begin
         if (req_data.opcode == OP_TICK) begin
            elapsed_in = elapsed_ff + 1'b1;
            // elapsed mod 100 and the parity of elapsed / 100, kept in step with time
            if (elapsed_ff == '1) begin
               flash_cnt_in = '0;
               flash_odd_in = 1'b0;
            end else if (flash_cnt_ff == FLASH_MS - 1'b1) begin
               flash_cnt_in = '0;
               flash_odd_in = !flash_odd_ff;
            end else begin
               flash_cnt_in = flash_cnt_ff + 1'b1;
            end
         end else if (req_data.new_mode != MODE_INVALID) begin
            if (req_data.new_mode == MODE_IDENTIFY) begin
               if (active_mode_ff != MODE_IDENTIFY) begin
                  saved_mode_in = active_mode_ff;
               end
               id_start_in = elapsed_ff;
            end
            active_mode_in = req_data.new_mode;
         end
      end
      // Frame start: mark time, end identify once it has run its course
      if (cmd.frame_start) begin
         last_frame_in = elapsed_ff;
         if (active_mode_ff == MODE_IDENTIFY && id_expired) begin
            active_mode_in = saved_mode_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff     <= '0;
         last_frame_ff  <= '0;
         id_start_ff    <= '0;
         active_mode_ff <= MODE_AMBER;
         saved_mode_ff  <= MODE_AMBER;
         flash_cnt_ff   <= '0;
         flash_odd_ff   <= 1'b0;
      end else begin
         elapsed_ff     <= elapsed_in;
         last_frame_ff  <= last_frame_in;
         id_start_ff    <= id_start_in;
         active_mode_ff <= active_mode_in;
         saved_mode_ff  <= saved_mode_in;
         flash_cnt_ff   <= flash_cnt_in;
         flash_odd_ff   <= flash_odd_in;
      end
   end

   // Shared divider and its operand selection
   logic [TENS_W-1:0] tens_clamped;
   logic [DIVR_W-1:0] period_ms;
   logic [TIME_W-1:0] div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic [PROD_W-1:0] idx_dividend;
   logic              div_done;
   logic [TIME_W-1:0] div_quot;
   logic [DIVR_W-1:0] div_rem;

   assign tens_clamped = (breath_tens_ff == '0) ? TENS_W'(1) : breath_tens_ff;
   assign period_ms    = DIVR_W'({tens_clamped, 3'b000}) + DIVR_W'({tens_clamped, 1'b0});
   assign idx_dividend = PROD_W'(div_rem) * PROD_W'(N_VAL);

   always_comb begin
      case (cmd.div_sel)
         DIV_MOD: begin
            div_dividend = elapsed_ff;
            div_divisor  = period_ms;
         end
         DIV_IDX: begin
            div_dividend = TIME_W'(idx_dividend);
            div_divisor  = period_ms;
         end
         default: begin
            div_dividend = elapsed_ff;
            div_divisor  = period_ms;
         end
      endcase
   end

   tlma_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Table lookup
   logic [IDX_W-1:0]  table_idx;
   logic [CHAN_W-1:0] bright_ff;

   assign table_idx = (div_quot >= TIME_W'(N)) ? IDX_MAX : div_quot[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_bright) begin
         bright_ff <= breath_rom[table_idx];
      end
   end

   // Scaling pipeline: percent products, then divide by 100 via reciprocal
   logic [SCALE_W-1:0]  prod_lvl_ff, prod_main_ff, prod_stby_ff;
   logic [SCALED_W-1:0] recip_lvl_ff, recip_main_ff, recip_stby_ff;

   always_ff @(posedge clock) begin
      prod_lvl_ff   <= SCALE_W'(bright_ff) * SCALE_W'(main_bright_ff);
      prod_main_ff  <= SCALE_W'({main_bright_ff, 8'h00}) - SCALE_W'(main_bright_ff);
      prod_stby_ff  <= SCALE_W'({stby_bright_ff, 8'h00}) - SCALE_W'(stby_bright_ff);
      recip_lvl_ff  <= SCALED_W'(prod_lvl_ff) * SCALED_W'(RECIP_100);
      recip_main_ff <= SCALED_W'(prod_main_ff) * SCALED_W'(RECIP_100);
      recip_stby_ff <= SCALED_W'(prod_stby_ff) * SCALED_W'(RECIP_100);
   end

   // Saturate the quotients to 8 bits
   localparam int QUOT_W = SCALED_W - RECIP_SHIFT;

   logic [QUOT_W-1:0]  q_lvl, q_main, q_stby;
   logic [CHAN_W-1:0]  lvl, solid_main, solid_stby;
   logic [SCALE_W-1:0] amber_prod;
   rsp_data_type       frame;

   assign q_lvl  = recip_lvl_ff[SCALED_W-1:RECIP_SHIFT];
   assign q_main = recip_main_ff[SCALED_W-1:RECIP_SHIFT];
   assign q_stby = recip_stby_ff[SCALED_W-1:RECIP_SHIFT];

   assign lvl        = (q_lvl  > QUOT_W'(255)) ? 8'hFF : q_lvl[CHAN_W-1:0];
   assign solid_main = (q_main > QUOT_W'(255)) ? 8'hFF : q_main[CHAN_W-1:0];
   assign solid_stby = (q_stby > QUOT_W'(255)) ? 8'hFF : q_stby[CHAN_W-1:0];

   // lvl * 96 as a shift-add
   assign amber_prod = SCALE_W'({lvl, 6'b000000}) + SCALE_W'({lvl, 5'b00000});

   // Frame color per mode
   always_comb begin
      frame            = '0;
      frame.shown_mode = active_mode_ff;
      case (active_mode_ff)
         MODE_PROGRAM: frame.red = solid_main;
         MODE_PREVIEW: frame.green = solid_main;
         MODE_STANDBY: begin
            frame.red   = solid_stby;
            frame.green = solid_stby;
            frame.blue  = solid_stby;
         end
         MODE_AMBER: begin
            frame.red   = lvl;
            frame.green = CHAN_W'(amber_prod[SCALE_W-1:8]);
         end
         MODE_WHITE_BREATH: begin
            frame.red   = lvl;
            frame.green = lvl;
            frame.blue  = lvl;
         end
         MODE_PAIRING: frame.blue = lvl;
         MODE_IDENTIFY: begin
            // on during even 100 ms windows
            if (!flash_odd_ff) begin
               frame.red   = 8'hFF;
               frame.green = 8'hFF;
               frame.blue  = 8'hFF;
            end
         end
         default: ;
      endcase
   end

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= frame;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the controller
   assign status.frame_due = ((elapsed_ff - last_frame_ff) >= FRAME_MS);
   assign status.mode      = active_mode_ff;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

[rtl/core/tlma_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlma_ctrl
   import tlma_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          item_opcode,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd,
   output logic               busy
);

   state_type state_ff, state_in;
   logic      is_breath;

   assign is_breath = status.mode inside {MODE_AMBER, MODE_WHITE_BREATH, MODE_PAIRING};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && item_opcode == OP_TICK) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:
            state_in = status.frame_due ? ST_SELECT : ST_IDLE;
         ST_SELECT: begin
            if (is_breath) begin
               state_in = ST_MOD_RUN;
            end else begin
               state_in = ST_SCALE_A;
            end
         end
         ST_MOD_RUN: begin
            if (status.div_done) begin
               state_in = ST_IDX_RUN;
            end
         end
         ST_IDX_RUN: begin
            if (status.div_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP:  state_in = ST_SCALE_A;
         ST_SCALE_A: state_in = ST_SCALE_B;
         ST_SCALE_B: state_in = ST_FORM;
         ST_FORM: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '{accept: 1'b0, frame_start: 1'b0, div_start: 1'b0, div_sel: DIV_MOD,
              load_bright: 1'b0, emit: 1'b0};
      case (state_ff)
         ST_IDLE:   cmd.accept = req_valid;
         ST_CHECK:  cmd.frame_start = status.frame_due;
         ST_SELECT: begin
            if (is_breath) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_MOD;
            end
         end
         ST_MOD_RUN: begin
            cmd.div_sel   = DIV_IDX;
            cmd.div_start = status.div_done;
         end
         ST_LOOKUP: cmd.load_bright = 1'b1;
         ST_FORM:   cmd.emit = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[rtl/core/tally_led_mode_animator.sv]
`timescale 1ns / 1ps
`default_nettype none

// A set-mode transaction is taken in the idle state; a tick with no frame due also passes
// through the frame check. A frame tick for solid modes and identify then runs select,
// the scaling states and form; breathing modes add two passes of the shared divider, then
// lookup, before scaling. Form registers the color once the previous one leaves rsp_stall.
// The next transaction is accepted when the item is done. Reset is synchronous, active
// high: time counters clear, mode is amber breathing, registers take their defaults.
module tally_led_mode_animator
   import tlma_pkg::*;
#(
   parameter int BREATH_TABLE_ENTRIES = 256
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_data_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_data_type               rsp_data,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          busy;

   tlma_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .item_opcode (req_data.opcode),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   tlma_dp #(
      .BREATH_TABLE_ENTRIES (BREATH_TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = busy;

endmodule

`default_nettype wire

[rtl/core/tlma_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlma_checker
   import tlma_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_data_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_data_type rsp_data
);

   // A stalled frame holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled frame changed");

   // A set-mode transaction leaves the block ready again in the following cycle
   a_set_mode_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_SET_MODE |=> !req_stall)
      else $error("set mode did not complete in one cycle");

   // A tick always enters the frame check
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_TICK |=> req_stall)
      else $error("tick did not enter frame check");

   // Program mode lights red only
   a_program_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.shown_mode == MODE_PROGRAM |->
         rsp_data.green == '0 && rsp_data.blue == '0)
      else $error("program frame not pure red");

   // Identify flashes full white or is dark
   a_identify_flash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.shown_mode == MODE_IDENTIFY |->
         rsp_data.red == rsp_data.green && rsp_data.red == rsp_data.blue &&
         (rsp_data.red == 8'h00 || rsp_data.red == 8'hFF))
      else $error("identify frame not white flash");

endmodule

bind tally_led_mode_animator tlma_checker u_tlma_checker (.*);

`default_nettype wire
